// ===== design/etn_pkg.sv =====
// Package for the expression text normalizer: transfer payload types,
// scanner state types, the function-name table and the name matcher.
// No dependencies; used by every module of the block.
package etn_pkg;

   localparam int MAX_CHARS = 256;
   localparam int CNT_W     = $clog2(MAX_CHARS + 1);
   localparam int NAME_NUM  = 10;

   typedef struct packed {
      logic [7:0] in_char;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       char_valid;
      logic       out_last;
      logic       name_error;
      logic       space_error;
      logic       length_error;
   } rsp_type;

   typedef logic [3:0][7:0] buf_type;

   typedef struct packed {
      logic at_operand_start;
      logic after_number;
      logic space_after_number;
   } scan_state_type;

   typedef struct packed {
      buf_type        buf_chars;
      logic [1:0]     hcount;
      logic [2:0]     count;
      scan_state_type sstate;
      logic           emit;
      logic [7:0]     emit_char;
      logic           name_err;
      logic           space_err;
   } scan_result_type;

   typedef struct packed {
      logic       full;
      logic       prefix;
      logic [7:0] code;
   } match_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   localparam logic [7:0] CH_SPACE  = " ";
   localparam logic [7:0] CH_LPAREN = "(";
   localparam logic [7:0] CH_PLUS   = "+";
   localparam logic [7:0] CH_MINUS  = "-";
   localparam logic [7:0] CH_TILDE  = "~";
   localparam logic [7:0] CH_DOT    = ".";
   localparam logic [7:0] CH_ZERO   = "0";
   localparam logic [7:0] CH_NINE   = "9";

   localparam logic [7:0] NAME_TEXT [NAME_NUM][4] = '{
      '{"a", "c", "o", "s"}, '{"a", "s", "i", "n"}, '{"a", "t", "a", "n"},
      '{"s", "q", "r", "t"}, '{"c", "o", "s", 8'h00}, '{"s", "i", "n", 8'h00},
      '{"t", "a", "n", 8'h00}, '{"l", "n", 8'h00, 8'h00},
      '{"l", "o", "g", 8'h00}, '{"m", "o", "d", 8'h00}};
   localparam logic [2:0] NAME_LEN [NAME_NUM] = '{
      3'd4, 3'd4, 3'd4, 3'd4, 3'd3, 3'd3, 3'd3, 3'd2, 3'd3, 3'd3};
   localparam logic [7:0] NAME_CODE [NAME_NUM] = '{
      "C", "S", "T", "q", "c", "s", "t", "n", "g", "m"};

   function automatic logic starts_name(input logic [7:0] c);
      return c == "c" || c == "s" || c == "t" || c == "a" || c == "l" || c == "m";
   endfunction

   function automatic match_type classify(input buf_type cand, input logic [2:0] len);
      match_type m;
      logic      hit;
      m = '0;
      for (int k = 0; k < NAME_NUM; k++) begin
         hit = (len <= NAME_LEN[k]);
         for (int i = 0; i < 4; i++) begin
            if (3'(i) < len && cand[i] != NAME_TEXT[k][i]) begin
               hit = 1'b0;
            end
         end
         if (hit && len == NAME_LEN[k]) begin
            m.full = 1'b1;
            m.code = NAME_CODE[k];
         end else if (hit) begin
            m.prefix = 1'b1;
         end
      end
      return m;
   endfunction

endpackage

// ===== design/etn_scan_unit.sv =====
// Shared scan step: takes one character of the work buffer through name
// matching, space checking and sign conversion. Depends on etn_pkg.
module etn_scan_unit (
   input  etn_pkg::buf_type         buf_chars,
   input  logic [1:0]               hcount,
   input  logic [2:0]               count,
   input  etn_pkg::scan_state_type  sstate,
   input  logic                     flush,
   output etn_pkg::scan_result_type res
);

   logic [7:0]          c;
   logic [7:0]          x;
   logic                do_space;
   logic [2:0]          shift;
   logic [2:0]          idx;
   logic                numeric;
   etn_pkg::match_type  m;

   always_comb begin
      c        = buf_chars[hcount];
      m        = etn_pkg::classify(buf_chars, {1'b0, hcount} + 3'd1);
      x        = c;
      do_space = 1'b0;
      shift    = 3'd0;
      res          = '0;
      res.hcount   = hcount;
      res.sstate   = sstate;

      if (flush) begin
         x            = buf_chars[0];
         do_space     = 1'b1;
         shift        = 3'd1;
         res.hcount   = 2'd0;
         res.name_err = 1'b1;
      end else if (hcount == 2'd0) begin
         if (etn_pkg::starts_name(c)) begin
            res.hcount = 2'd1;
         end else begin
            do_space = 1'b1;
            shift    = 3'd1;
         end
      end else if (m.full) begin
         x          = m.code;
         do_space   = 1'b1;
         shift      = {1'b0, hcount} + 3'd1;
         res.hcount = 2'd0;
      end else if (m.prefix && hcount != 2'd3) begin
         res.hcount = hcount + 2'd1;
      end else begin
         x            = buf_chars[0];
         do_space     = 1'b1;
         shift        = 3'd1;
         res.hcount   = 2'd0;
         res.name_err = 1'b1;
      end

      for (int i = 0; i < 4; i++) begin
         idx = 3'(i) + shift;
         res.buf_chars[i] = (idx < 3'd4) ? buf_chars[idx[1:0]] : 8'h00;
      end
      res.count = count - shift;

      numeric = (x >= etn_pkg::CH_ZERO && x <= etn_pkg::CH_NINE) || x == etn_pkg::CH_DOT;
      res.emit_char = x;
      if (do_space) begin
         if (x == etn_pkg::CH_SPACE) begin
            if (sstate.after_number) begin
               res.sstate.space_after_number = 1'b1;
            end
         end else begin
            if (numeric) begin
               if (sstate.after_number && sstate.space_after_number) begin
                  res.space_err = 1'b1;
               end
               res.sstate.after_number = 1'b1;
            end else begin
               res.sstate.after_number = 1'b0;
            end
            res.sstate.space_after_number = 1'b0;
            res.emit = 1'b1;
            if (x == etn_pkg::CH_LPAREN) begin
               res.sstate.at_operand_start = 1'b1;
            end else if (sstate.at_operand_start) begin
               res.sstate.at_operand_start = 1'b0;
               if (x == etn_pkg::CH_PLUS) begin
                  res.emit = 1'b0;
               end else if (x == etn_pkg::CH_MINUS) begin
                  res.emit_char = etn_pkg::CH_TILDE;
               end
            end
         end
      end
   end

endmodule

// ===== design/etn_rsp_reg.sv =====
// Result output register: holds one result transfer until the consumer
// takes it. Depends on etn_pkg.
module etn_rsp_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  etn_pkg::rsp_type load_data,
   output logic             free,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output etn_pkg::rsp_type rsp_data
);

   logic             valid_ff, valid_in;
   etn_pkg::rsp_type data_ff, data_in;

   always_comb begin
      free     = !valid_ff || !rsp_stall;
      valid_in = valid_ff && !free;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = load_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ===== design/expression_text_normalizer.sv =====
// Expression text normalizer, top level: sequencer around the shared scan
// unit and the result register. Depends on etn_pkg, etn_scan_unit, etn_rsp_reg.
// Per character: an accept step, then scan steps (failed names and end-of-text
// flushes rescan held letters), a done check and a finish step; scan steps and
// the finish step can wait on a stalled result register.
// Synchronous active-high reset clears the sequencer and scan state, but not the work buffer or the pending character.
module expression_text_normalizer (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  etn_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output etn_pkg::rsp_type rsp_data
);

   etn_pkg::state_type       state_ff, state_in;
   etn_pkg::buf_type         buf_ff, buf_in;
   logic [1:0]               hcount_ff, hcount_in;
   logic [2:0]               count_ff, count_in;
   etn_pkg::scan_state_type  sstate_ff, sstate_in;
   logic                     name_err_ff, name_err_in;
   logic                     space_err_ff, space_err_in;
   logic                     len_over_ff, len_over_in;
   logic [etn_pkg::CNT_W-1:0] char_count_ff, char_count_in;
   logic                     last_ff, last_in;
   logic                     pend_valid_ff, pend_valid_in;
   logic [7:0]               pend_char_ff, pend_char_in;

   logic                     flush;
   logic                     work;
   logic                     step_ok;
   logic                     load;
   logic                     free;
   etn_pkg::rsp_type         load_data;
   etn_pkg::scan_result_type res;

   assign flush = last_ff && hcount_ff != 2'd0 && {1'b0, hcount_ff} == count_ff;
   assign work  = ({1'b0, hcount_ff} != count_ff) || flush;

   etn_scan_unit u_scan (
      .buf_chars (buf_ff),
      .hcount    (hcount_ff),
      .count     (count_ff),
      .sstate    (sstate_ff),
      .flush     (flush),
      .res       (res)
   );

   etn_rsp_reg u_rsp (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .load_data (load_data),
      .free      (free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign req_stall = (state_ff != etn_pkg::ST_IDLE);
   assign step_ok   = free || !pend_valid_ff;

   always_comb begin
      state_in      = state_ff;
      buf_in        = buf_ff;
      hcount_in     = hcount_ff;
      count_in      = count_ff;
      sstate_in     = sstate_ff;
      name_err_in   = name_err_ff;
      space_err_in  = space_err_ff;
      len_over_in   = len_over_ff;
      char_count_in = char_count_ff;
      last_in       = last_ff;
      pend_valid_in = pend_valid_ff;
      pend_char_in  = pend_char_ff;
      load          = 1'b0;
      load_data     = '0;
      load_data.out_char   = pend_char_ff;
      load_data.char_valid = pend_valid_ff;

      case (state_ff)
         etn_pkg::ST_IDLE: begin
            if (req_valid) begin
               last_in  = req_data.in_last;
               state_in = etn_pkg::ST_SCAN;
               if (char_count_ff < etn_pkg::CNT_W'(etn_pkg::MAX_CHARS)) begin
                  char_count_in           = char_count_ff + etn_pkg::CNT_W'(1);
                  buf_in[count_ff[1:0]]   = req_data.in_char;
                  count_in                = count_ff + 3'd1;
               end else begin
                  len_over_in = 1'b1;
               end
            end
         end
         etn_pkg::ST_SCAN: begin
            if (!work) begin
               state_in = etn_pkg::ST_FINISH;
            end else if (step_ok) begin
               buf_in       = res.buf_chars;
               hcount_in    = res.hcount;
               count_in     = res.count;
               sstate_in    = res.sstate;
               name_err_in  = name_err_ff || res.name_err;
               space_err_in = space_err_ff || res.space_err;
               if (res.emit) begin
                  load          = pend_valid_ff;
                  pend_valid_in = 1'b1;
                  pend_char_in  = res.emit_char;
               end
            end
         end
         etn_pkg::ST_FINISH: begin
            if (!pend_valid_ff && !last_ff) begin
               state_in = etn_pkg::ST_IDLE;
            end else if (free) begin
               load                   = 1'b1;
               load_data.out_char     = pend_valid_ff ? pend_char_ff : 8'h00;
               load_data.out_last     = last_ff;
               load_data.name_error   = last_ff && name_err_ff;
               load_data.space_error  = last_ff && space_err_ff;
               load_data.length_error = last_ff && len_over_ff;
               pend_valid_in          = 1'b0;
               state_in               = etn_pkg::ST_IDLE;
               if (last_ff) begin
                  hcount_in     = 2'd0;
                  count_in      = 3'd0;
                  sstate_in     = '{at_operand_start: 1'b1, after_number: 1'b0,
                                    space_after_number: 1'b0};
                  name_err_in   = 1'b0;
                  space_err_in  = 1'b0;
                  len_over_in   = 1'b0;
                  char_count_in = '0;
               end
            end
         end
         default: begin
            state_in = etn_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= etn_pkg::ST_IDLE;
         hcount_ff     <= 2'd0;
         count_ff      <= 3'd0;
         sstate_ff     <= '{at_operand_start: 1'b1, after_number: 1'b0,
                            space_after_number: 1'b0};
         name_err_ff   <= 1'b0;
         space_err_ff  <= 1'b0;
         len_over_ff   <= 1'b0;
         char_count_ff <= '0;
         last_ff       <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         hcount_ff     <= hcount_in;
         count_ff      <= count_in;
         sstate_ff     <= sstate_in;
         name_err_ff   <= name_err_in;
         space_err_ff  <= space_err_in;
         len_over_ff   <= len_over_in;
         char_count_ff <= char_count_in;
         last_ff       <= last_in;
         pend_valid_ff <= pend_valid_in;
      end
      buf_ff       <= buf_in;
      pend_char_ff <= pend_char_in;
   end

endmodule
